### rtl/core/mdad_pkg.sv
// Package with request, result and descriptor types for the memory descriptor address decoder.
package mdad_pkg;

  // Default number of region descriptor slots.
  localparam int unsigned REGION_SLOTS_DEF = 8;

  // Request opcodes.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // One request on the input channel.
  typedef struct packed {
    logic        opcode;
    logic [2:0]  slot_index;
    logic [31:0] guest_address;
    logic [31:0] new_start;
    logic [31:0] new_select;
    logic [31:0] new_disconnect;
    logic [31:0] new_length;
    logic [31:0] new_offset;
  } in_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic        hit;
    logic [2:0]  hit_slot;
    logic [32:0] host_offset;
  } out_res_t;

  // One stored region descriptor.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] select;
    logic [31:0] disconnect;
    logic [31:0] length;
    logic [31:0] offset;
  } slot_desc_t;

endpackage

### rtl/core/memory_descriptor_address_decode.sv
// Top level of the memory descriptor address decoder with its slot memory and sequencer.
//
//   Channel   Ports                 Handshake
//   request   start, busy, in_req   taken at a clock edge with start high and busy low
//   result    out_strobe, out_res   shown for one cycle while out_strobe is high
//
// A write request is stored when it is taken and gives no result; busy stays low.
// A resolve request walks the slots in index order through one descriptor read port and one
// shared subtract, compare and bit-squeeze unit: each slot passes a fetch and a check state,
// and a slot whose select compare passes adds a squeeze step per set disconnect bit and a
// length compare; a hit ends in a finish state that forms the offset. The result strobe
// rises at the edge where busy falls and lasts one cycle; the receiver cannot stall it.
// Reset clears the slot valid bits and the sequencer; descriptor contents need no reset.
module memory_descriptor_address_decode
  import mdad_pkg::*;
#(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  localparam int unsigned SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FETCH   = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_SQUEEZE = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [SLOT_W-1:0]       slot_cnt_r, slot_cnt_nxt;
  logic [31:0]             addr_r, addr_nxt;
  logic [31:0]             val_r, val_nxt;
  logic [31:0]             mask_r, mask_nxt;
  logic [REGION_SLOTS-1:0] valid_r, valid_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  out_res_t                out_res_r, out_res_nxt;
  slot_desc_t              rd_data_r;
  slot_desc_t              slot_mem [REGION_SLOTS];

  logic                    accept;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  slot_desc_t              wr_data;
  logic                    last_slot;
  logic [32:0]             diff;
  logic                    range_hit;
  logic                    sel_hit;
  logic [31:0]             below;

  assign accept    = start && (state_r == S_IDLE);
  assign wr_en     = accept && (in_req.opcode == OP_WRITE) &&
                     ({29'd0, in_req.slot_index} < REGION_SLOTS);
  assign wr_addr   = SLOT_W'(in_req.slot_index);
  assign wr_data   = '{start:      in_req.new_start,
                       select:     in_req.new_select,
                       disconnect: in_req.new_disconnect,
                       length:     in_req.new_length,
                       offset:     in_req.new_offset};
  assign last_slot = ({{(32-SLOT_W){1'b0}}, slot_cnt_r} == REGION_SLOTS - 1);

  // Shared unit: address minus start with borrow, and the select-mask compare.
  assign diff      = {1'b0, addr_r} - {1'b0, rd_data_r.start};
  assign range_hit = !diff[32] && (diff[31:0] < rd_data_r.length);
  assign sel_hit   = ((addr_r ^ rd_data_r.start) & rd_data_r.select) == 32'd0;

  // One squeeze step removes the lowest disconnect bit from the reduced address.
  assign below     = (mask_r - 32'd1) & ~mask_r;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    slot_cnt_nxt   = slot_cnt_r;
    addr_nxt       = addr_r;
    val_nxt        = val_r;
    mask_nxt       = mask_r;
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    case (state_r)
      S_IDLE: begin
        if (wr_en) begin
          valid_nxt[wr_addr] = (in_req.new_length != 32'd0);
        end
        if (accept && (in_req.opcode == OP_RESOLVE)) begin
          addr_nxt     = in_req.guest_address;
          slot_cnt_nxt = '0;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (valid_r[slot_cnt_r] && (rd_data_r.select == 32'd0) && range_hit) begin
          val_nxt   = diff[31:0];
          state_nxt = S_FINISH;
        end else if (valid_r[slot_cnt_r] && (rd_data_r.select != 32'd0) && sel_hit) begin
          val_nxt   = diff[31:0];
          mask_nxt  = rd_data_r.disconnect;
          state_nxt = S_SQUEEZE;
        end else if (last_slot) begin
          out_strobe_nxt = 1'b1;
          out_res_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          slot_cnt_nxt = slot_cnt_r + SLOT_W'(1);
          state_nxt    = S_FETCH;
        end
      end
      S_SQUEEZE: begin
        if (mask_r != 32'd0) begin
          val_nxt  = (val_r & below) | ((val_r >> 1) & ~below);
          mask_nxt = (mask_r & (mask_r - 32'd1)) >> 1;
        end else if (val_r < rd_data_r.length) begin
          state_nxt = S_FINISH;
        end else if (last_slot) begin
          out_strobe_nxt = 1'b1;
          out_res_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          slot_cnt_nxt = slot_cnt_r + SLOT_W'(1);
          state_nxt    = S_FETCH;
        end
      end
      S_FINISH: begin
        out_strobe_nxt          = 1'b1;
        out_res_nxt.hit         = 1'b1;
        out_res_nxt.hit_slot    = 3'(slot_cnt_r);
        out_res_nxt.host_offset = {1'b0, rd_data_r.offset} + {1'b0, val_r};
        state_nxt               = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    slot_cnt_r <= slot_cnt_nxt;
    addr_r     <= addr_nxt;
    val_r      <= val_nxt;
    mask_r     <= mask_nxt;
    out_res_r  <= out_res_nxt;
  end

  // Descriptor memory: one write port from requests, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (state_r == S_FETCH) begin
      rd_data_r <= slot_mem[slot_cnt_r];
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
